// ===== sv/mpg_pkg.sv =====
package mpg_pkg;

  localparam int VALUE_BITS = 8;
  localparam int SLOTS      = 4;
  localparam int PIVOTS     = SLOTS - 1;

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef val_t [SLOTS-1:0]      order_t;

  typedef struct packed {
    val_t value_a;
    val_t value_b;
    val_t value_c;
    val_t value_d;
  } item_t;

  typedef struct packed {
    val_t perm_a;
    val_t perm_b;
    val_t perm_c;
    val_t perm_d;
    logic is_last;
  } result_t;

  // What one pivot lane proposes as the next arrangement.
  typedef struct packed {
    logic   found;
    order_t order;
  } lane_res_t;

  // Merged step: the next arrangement, or last when no lane found a pivot.
  typedef struct packed {
    logic   last;
    order_t order;
  } step_t;

endpackage

// ===== sv/mpg_sort.sv =====
module mpg_sort (
  input  mpg_pkg::order_t unsorted,
  output mpg_pkg::order_t sorted
);
  import mpg_pkg::*;

  order_t s1;
  order_t s2;

  // Five compare-exchange cells of a four-input sorting network.
  always_comb begin
    s1 = unsorted;
    if (s1[0] > s1[1]) begin
      s1[0] = unsorted[1];
      s1[1] = unsorted[0];
    end
    if (s1[2] > s1[3]) begin
      s1[2] = unsorted[3];
      s1[3] = unsorted[2];
    end

    s2 = s1;
    if (s1[0] > s1[2]) begin
      s2[0] = s1[2];
      s2[2] = s1[0];
    end
    if (s1[1] > s1[3]) begin
      s2[1] = s1[3];
      s2[3] = s1[1];
    end

    sorted = s2;
    if (s2[1] > s2[2]) begin
      sorted[1] = s2[2];
      sorted[2] = s2[1];
    end
  end

endmodule

// ===== sv/mpg_lane.sv =====
module mpg_lane #(
  parameter int PIVOT = 0
) (
  input  mpg_pkg::order_t   cur,
  output mpg_pkg::lane_res_t res
);
  import mpg_pkg::*;

  logic [1:0] succ;
  order_t     swapped;

  // This lane assumes its own slot is the pivot and builds the next
  // arrangement from that guess; the merge keeps the rightmost true pivot.
  always_comb begin
    succ = 2'(PIVOT + 1);
    for (int j = PIVOT + 1; j < SLOTS; j++) begin
      if (cur[j] > cur[PIVOT]) begin
        succ = 2'(j);
      end
    end

    swapped          = cur;
    swapped[PIVOT]   = cur[succ];
    swapped[succ]    = cur[PIVOT];

    res.found = cur[PIVOT] < cur[PIVOT+1];
    res.order = swapped;
    for (int i = PIVOT + 1; i < SLOTS; i++) begin
      res.order[i] = swapped[PIVOT + SLOTS - i];
    end
  end

endmodule

// ===== sv/mpg_merge.sv =====
module mpg_merge (
  input  mpg_pkg::order_t                    cur,
  input  mpg_pkg::lane_res_t [mpg_pkg::PIVOTS-1:0] lanes,
  output mpg_pkg::step_t                     step
);
  import mpg_pkg::*;

  always_comb begin
    step.last  = 1'b0;
    step.order = cur;
    priority if (lanes[2].found) begin
      step.order = lanes[2].order;
    end else if (lanes[1].found) begin
      step.order = lanes[1].order;
    end else if (lanes[0].found) begin
      step.order = lanes[0].order;
    end else begin
      step.last = 1'b1;
    end
  end

endmodule

// ===== sv/multiset_permutation_generator_unit.sv =====
// Multiset permutation generator.
// A word of four unsigned values is taken on item when start is high and
// busy is low. The block sorts the word and then produces every distinct
// arrangement of it in lexicographic order, the sorted one first. Each
// arrangement appears on result for exactly one cycle with strobe high;
// result.is_last marks the greatest arrangement, the final word of the item.
// The combinational sorting network orders the word on item, which is
// loaded into cur at the accepting edge and then registered as the first
// result; the rest follow one per cycle with no gaps. An item has N
// distinct arrangements (1 to 24), produced by one next-permutation step
// per cycle, each decided by three pivot lanes working in parallel and a merge.
// busy drops while the last result is on the port, so a new item can be
// accepted in that cycle. The receiver cannot stall; it must take each
// word in the cycle it is shown. Synchronous reset clears busy and strobe
// and abandons any item in progress.
module multiset_permutation_generator_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mpg_pkg::item_t   item,
  output mpg_pkg::result_t result,
  output logic             strobe
);
  import mpg_pkg::*;

  order_t                in_order;
  order_t                sorted;
  order_t                cur;
  logic                  generating;
  lane_res_t [PIVOTS-1:0] lanes;
  step_t                 step;
  logic                  accept;

  assign in_order = '{item.value_d, item.value_c, item.value_b, item.value_a};
  assign accept   = start && !busy;
  assign busy     = generating;

  mpg_sort u_sort (
    .unsorted (in_order),
    .sorted   (sorted)
  );

  for (genvar p = 0; p < PIVOTS; p++) begin : g_lane
    mpg_lane #(.PIVOT(p)) u_lane (
      .cur (cur),
      .res (lanes[p])
    );
  end

  mpg_merge u_merge (
    .cur   (cur),
    .lanes (lanes),
    .step  (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      generating <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= generating;
      if (accept) begin
        generating <= 1'b1;
      end else if (generating && step.last) begin
        generating <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= sorted;
    end else if (generating) begin
      cur <= step.order;
    end
    if (generating) begin
      result.perm_a  <= cur[0];
      result.perm_b  <= cur[1];
      result.perm_c  <= cur[2];
      result.perm_d  <= cur[3];
      result.is_last <= step.last;
    end
  end

  a_strobe_from_work: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result word shown without work in progress");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.is_last) |=> strobe)
    else $error("gap inside an item's result sequence");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.is_last) |=> !strobe)
    else $error("result word after the last arrangement");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

endmodule

// ===== tb/sv/tb_multiset_permutation_generator_unit.sv =====
module tb_multiset_permutation_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mpg_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_WORDS = 80;

  // Expected arrangements, in the order the block must produce them.
  class arrangement_board;
    result_t pending[$];
    int      mismatches;

    function void note_word(item_t w);
      val_t    v [SLOTS];
      val_t    t;
      int      piv;
      int      succ;
      int      lo;
      int      hi;
      bit      more;
      result_t r;
      v[0] = w.value_a;
      v[1] = w.value_b;
      v[2] = w.value_c;
      v[3] = w.value_d;
      for (int p = 1; p < SLOTS; p++) begin
        for (int q = p; q > 0 && v[q-1] > v[q]; q--) begin
          t = v[q];
          v[q] = v[q-1];
          v[q-1] = t;
        end
      end
      do begin
        r.perm_a = v[0];
        r.perm_b = v[1];
        r.perm_c = v[2];
        r.perm_d = v[3];
        // The pivot is the rightmost slot smaller than its right neighbor.
        piv = SLOTS - 2;
        while (piv >= 0 && v[piv] >= v[piv+1]) piv--;
        more = (piv >= 0);
        r.is_last = !more;
        pending.push_back(r);
        if (more) begin
          succ = SLOTS - 1;
          while (v[piv] >= v[succ]) succ--;
          t = v[piv];
          v[piv] = v[succ];
          v[succ] = t;
          lo = piv + 1;
          hi = SLOTS - 1;
          while (lo < hi) begin
            t = v[lo];
            v[lo] = v[hi];
            v[hi] = t;
            lo++;
            hi--;
          end
        end
      end while (more);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: %0d %0d %0d %0d last=%0b",
                   got.perm_a, got.perm_b, got.perm_c, got.perm_d, got.is_last);
        return;
      end
      want = pending.pop_front();
      if (got.perm_a !== want.perm_a || got.perm_b !== want.perm_b ||
          got.perm_c !== want.perm_c || got.perm_d !== want.perm_d ||
          got.is_last !== want.is_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected %0d %0d %0d %0d last=%0b, ",
                    "got %0d %0d %0d %0d last=%0b"},
                   want.perm_a, want.perm_b, want.perm_c, want.perm_d, want.is_last,
                   got.perm_a, got.perm_b, got.perm_c, got.perm_d, got.is_last);
      end
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  result_t result;
  logic    strobe;
  int      stall_cycles;

  arrangement_board ledger;

  multiset_permutation_generator_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .result (result),
    .strobe (strobe)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Inputs and outputs are sampled here with their values from before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) ledger.note_word(item);
      if (strobe) ledger.check_word(result);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_multiset_permutation_generator_unit: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Holds the word on the port until an edge sees start high and busy low.
  task automatic push_word(input item_t w);
    item  <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  // One edge first, so the word accepted at the last edge is already noted.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.pending.size() != 0) @(posedge clk);
  endtask

  // Small value pools make repeated values, and so fewer arrangements, common.
  function automatic item_t random_word();
    val_t  pool [3];
    int    mode;
    item_t w;
    mode = $urandom_range(3);
    pool[0] = val_t'($urandom_range(255));
    pool[1] = (mode == 3) ? val_t'(0) : val_t'($urandom_range(255));
    pool[2] = (mode == 3) ? val_t'(255) : val_t'($urandom_range(255));
    if (mode == 0) begin
      w = $urandom;
    end else begin
      w.value_a = pool[$urandom_range(mode == 1 ? 1 : 2)];
      w.value_b = pool[$urandom_range(mode == 1 ? 1 : 2)];
      w.value_c = pool[$urandom_range(mode == 1 ? 1 : 2)];
      w.value_d = pool[$urandom_range(mode == 1 ? 1 : 2)];
    end
    return w;
  endfunction

  initial begin
    item_t directed [$];
    int    idle_pct [3];
    ledger = new();
    rst    = 1'b1;
    start  = 1'b0;
    item   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Equal values give one arrangement, four distinct ones give all 24.
    directed.push_back('{8'd0, 8'd0, 8'd0, 8'd0});
    directed.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
    directed.push_back('{8'h5a, 8'h5a, 8'h5a, 8'h5a});
    directed.push_back('{8'd1, 8'd2, 8'd3, 8'd4});
    directed.push_back('{8'd4, 8'd3, 8'd2, 8'd1});
    directed.push_back('{8'd255, 8'd0, 8'd128, 8'd1});
    directed.push_back('{8'd7, 8'd7, 8'd3, 8'd3});
    directed.push_back('{8'd9, 8'd9, 8'd9, 8'd1});
    directed.push_back('{8'd0, 8'd0, 8'd0, 8'd255});
    directed.push_back('{8'd255, 8'd0, 8'd255, 8'd0});
    directed.push_back('{8'haa, 8'h55, 8'haa, 8'h55});
    directed.push_back('{8'h80, 8'h01, 8'h7f, 8'hfe});
    directed.push_back('{8'd0, 8'd255, 8'd0, 8'd0});
    directed.push_back('{8'd3, 8'd1, 8'd2, 8'd2});
    foreach (directed[k]) push_word(directed[k]);
    drain_results();

    idle_pct[0] = 35;
    idle_pct[1] = 81;
    idle_pct[2] = 0;
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < PHASE_WORDS; n++) begin
        sender_gap(idle_pct[ph]);
        push_word(random_word());
      end
      // After the first phase only, hold off the next word until the block has emptied.
      if (ph == 0) drain_results();
    end

    drain_results();
    repeat (4) @(posedge clk);
    ledger.mismatches += ledger.pending.size();
    if (ledger.mismatches == 0) begin
      $display("tb_multiset_permutation_generator_unit: clean");
    end else begin
      $display("tb_multiset_permutation_generator_unit: errors");
    end
    $finish;
  end

endmodule
